// ===== rtl/core/fdf_pkg.sv =====
// shared types, constants and defaults for the fall detector
package fdf_pkg;

  localparam int AVG_WINDOW_DEF = 5;
  localparam int QDEPTH         = 2;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int MAG_W          = 16;
  localparam int TS_W           = 32;
  localparam int SQ_W           = 32;
  localparam int ROOT_STEPS     = 16;

  localparam logic [MAG_W-1:0] MAG_MAX = 16'd56755;

  localparam logic [CFG_IDX_W-1:0] CFG_FREEFALL_LEVEL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMPACT_LEVEL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_LEVEL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FREEFALL_MAX_MS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_MS       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_MS      = 3'd5;

  localparam logic [CFG_DATA_W-1:0] DEF_FREEFALL_LEVEL  = 16'd1229;
  localparam logic [CFG_DATA_W-1:0] DEF_IMPACT_LEVEL    = 16'd10240;
  localparam logic [CFG_DATA_W-1:0] DEF_RECOVERY_LEVEL  = 16'd3277;
  localparam logic [CFG_DATA_W-1:0] DEF_FREEFALL_MAX_MS = 16'd500;
  localparam logic [CFG_DATA_W-1:0] DEF_SETTLE_MS       = 16'd200;
  localparam logic [CFG_DATA_W-1:0] DEF_CONFIRM_MS      = 16'd3000;

  typedef enum logic [2:0] {
    PH_NORMAL    = 3'd0,
    PH_FREEFALL  = 3'd1,
    PH_IMPACT    = 3'd2,
    PH_POSSIBLE  = 3'd3,
    PH_CONFIRMED = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_SQUARE,
    FR_ROOT,
    FR_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SUM,
    BK_DECIDE,
    BK_OUT
  } back_state_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic [TS_W-1:0]  now_ms;
  } sample_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] freefall_level;
    logic [CFG_DATA_W-1:0] impact_level;
    logic [CFG_DATA_W-1:0] recovery_level;
    logic [CFG_DATA_W-1:0] freefall_max_ms;
    logic [CFG_DATA_W-1:0] settle_ms;
    logic [CFG_DATA_W-1:0] confirm_ms;
  } cfg_t;

endpackage

// ===== rtl/core/fdf_front.sv =====
// front end: accepts samples, sums squares and takes the integer square root
module fdf_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [15:0]       accel_x,
  input  logic signed [15:0]       accel_y,
  input  logic signed [15:0]       accel_z,
  input  logic [fdf_pkg::TS_W-1:0] now_ms,
  output logic                     q_wvalid,
  input  logic                     q_wready,
  output fdf_pkg::sample_t         q_wdata
);

  fdf_pkg::front_state_t st_r, st_nxt;
  logic signed [15:0] ax_r, ay_r, az_r;
  logic [fdf_pkg::TS_W-1:0] now_r;
  logic [3:0] cnt_r, cnt_nxt;
  logic [fdf_pkg::SQ_W-1:0] acc_r, acc_nxt;
  logic [fdf_pkg::SQ_W-1:0] rad_r, rad_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] root_r, root_nxt;

  logic signed [15:0] sel;
  logic signed [31:0] sq;
  logic [18:0] rem_t;
  logic [18:0] trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= fdf_pkg::FR_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ax_r  <= accel_x;
      ay_r  <= accel_y;
      az_r  <= accel_z;
      now_r <= now_ms;
    end
    cnt_r  <= cnt_nxt;
    acc_r  <= acc_nxt;
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    sel = ax_r;
      2'd1:    sel = ay_r;
      default: sel = az_r;
    endcase
    sq    = sel * sel;
    rem_t = {rem_r, rad_r[fdf_pkg::SQ_W-1 -: 2]};
    trial = {1'b0, root_r, 2'b01};
  end

  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    in_ready = 1'b0;
    q_wvalid = 1'b0;
    case (st_r)
      fdf_pkg::FR_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          st_nxt  = fdf_pkg::FR_SQUARE;
          cnt_nxt = 4'd0;
          acc_nxt = '0;
        end
      end
      fdf_pkg::FR_SQUARE: begin
        acc_nxt = acc_r + unsigned'(sq);
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r[1:0] == 2'd2) begin
          st_nxt   = fdf_pkg::FR_ROOT;
          cnt_nxt  = 4'd0;
          rad_nxt  = acc_r + unsigned'(sq);
          rem_nxt  = '0;
          root_nxt = '0;
        end
      end
      fdf_pkg::FR_ROOT: begin
        rad_nxt = {rad_r[fdf_pkg::SQ_W-3:0], 2'b00};
        if (rem_t >= trial) begin
          rem_nxt  = 17'(rem_t - trial);
          root_nxt = {root_r[14:0], 1'b1};
        end else begin
          rem_nxt  = 17'(rem_t);
          root_nxt = {root_r[14:0], 1'b0};
        end
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'(fdf_pkg::ROOT_STEPS - 1)) begin
          st_nxt = fdf_pkg::FR_PUSH;
        end
      end
      fdf_pkg::FR_PUSH: begin
        q_wvalid = 1'b1;
        if (q_wready) begin
          st_nxt = fdf_pkg::FR_IDLE;
        end
      end
      default: begin
        st_nxt = fdf_pkg::FR_IDLE;
      end
    endcase
  end

  assign q_wdata.mag    = root_r;
  assign q_wdata.now_ms = now_r;

endmodule

// ===== rtl/core/fdf_queue.sv =====
// two-entry sample queue between front and back
module fdf_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wvalid,
  output logic             wready,
  input  fdf_pkg::sample_t wdata,
  output logic             rvalid,
  input  logic             rready,
  output fdf_pkg::sample_t rdata
);

  localparam int PW = $clog2(fdf_pkg::QDEPTH);
  localparam int CW = $clog2(fdf_pkg::QDEPTH + 1);

  fdf_pkg::sample_t mem_r [fdf_pkg::QDEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic push, pop;

  assign wready = (cnt_r != CW'(fdf_pkg::QDEPTH));
  assign rvalid = (cnt_r != '0);
  assign push   = wvalid && wready;
  assign pop    = rvalid && rready;
  assign rdata  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(fdf_pkg::QDEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(fdf_pkg::QDEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== rtl/core/fdf_back.sv =====
// back end: magnitude window, stillness sum, phase machine and result register
module fdf_back #(
  parameter int AVG_WINDOW = fdf_pkg::AVG_WINDOW_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  fdf_pkg::cfg_t    cfg,
  input  logic             q_rvalid,
  output logic             q_rready,
  input  fdf_pkg::sample_t q_rdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [23:0]      out_tdata
);

  localparam int PW = (AVG_WINDOW > 1) ? $clog2(AVG_WINDOW) : 1;
  localparam int SW = fdf_pkg::MAG_W + $clog2(AVG_WINDOW + 1);

  fdf_pkg::back_state_t st_r, st_nxt;
  fdf_pkg::phase_t phase_r, phase_nxt;
  logic [fdf_pkg::MAG_W-1:0] win_r [AVG_WINDOW];
  logic [PW-1:0] wp_r, idx_r, idx_nxt;
  logic [SW-1:0] sum_r, sum_nxt;
  logic [fdf_pkg::MAG_W-1:0] mag_r;
  logic [fdf_pkg::TS_W-1:0] now_r, ffs_r, ffs_nxt, imp_r, imp_nxt;
  logic [23:0] tdata_r, tdata_nxt;
  logic tvalid_r, tvalid_nxt;
  logic pop;

  logic [fdf_pkg::TS_W-1:0] dt_ff, dt_imp;
  logic [SW-1:0] thr;

  assign pop        = q_rvalid && q_rready;
  assign q_rready   = (st_r == fdf_pkg::BK_IDLE);
  assign out_tvalid = tvalid_r;
  assign out_tdata  = tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= fdf_pkg::BK_IDLE;
      phase_r  <= fdf_pkg::PH_NORMAL;
      ffs_r    <= '0;
      imp_r    <= '0;
      wp_r     <= '0;
      tvalid_r <= 1'b0;
      for (int i = 0; i < AVG_WINDOW; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      st_r     <= st_nxt;
      phase_r  <= phase_nxt;
      ffs_r    <= ffs_nxt;
      imp_r    <= imp_nxt;
      tvalid_r <= tvalid_nxt;
      if (pop) begin
        win_r[wp_r] <= q_rdata.mag;
        wp_r <= (wp_r == PW'(AVG_WINDOW - 1)) ? '0 : wp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      mag_r <= q_rdata.mag;
      now_r <= q_rdata.now_ms;
    end
    idx_r   <= idx_nxt;
    sum_r   <= sum_nxt;
    tdata_r <= tdata_nxt;
  end

  always_comb begin
    dt_ff  = now_r - ffs_r;
    dt_imp = now_r - imp_r;
    thr    = SW'(32'(cfg.freefall_level) * AVG_WINDOW);
  end

  always_comb begin
    st_nxt     = st_r;
    phase_nxt  = phase_r;
    ffs_nxt    = ffs_r;
    imp_nxt    = imp_r;
    idx_nxt    = idx_r;
    sum_nxt    = sum_r;
    tdata_nxt  = tdata_r;
    tvalid_nxt = tvalid_r;
    case (st_r)
      fdf_pkg::BK_IDLE: begin
        if (q_rvalid) begin
          st_nxt  = fdf_pkg::BK_SUM;
          idx_nxt = '0;
          sum_nxt = '0;
        end
      end
      fdf_pkg::BK_SUM: begin
        sum_nxt = sum_r + SW'(win_r[idx_r]);
        idx_nxt = idx_r + 1'b1;
        if (idx_r == PW'(AVG_WINDOW - 1)) begin
          st_nxt = fdf_pkg::BK_DECIDE;
        end
      end
      fdf_pkg::BK_DECIDE: begin
        case (phase_r)
          fdf_pkg::PH_FREEFALL: begin
            if (mag_r > cfg.impact_level) begin
              phase_nxt = fdf_pkg::PH_IMPACT;
              imp_nxt   = now_r;
            end else if (dt_ff > fdf_pkg::TS_W'(cfg.freefall_max_ms)) begin
              phase_nxt = fdf_pkg::PH_NORMAL;
            end
          end
          fdf_pkg::PH_IMPACT: begin
            if (dt_imp > fdf_pkg::TS_W'(cfg.settle_ms)) begin
              phase_nxt = (sum_r < thr) ? fdf_pkg::PH_POSSIBLE : fdf_pkg::PH_NORMAL;
            end
          end
          fdf_pkg::PH_POSSIBLE: begin
            if (dt_imp > fdf_pkg::TS_W'(cfg.confirm_ms)) begin
              phase_nxt = fdf_pkg::PH_CONFIRMED;
            end else if (mag_r > cfg.recovery_level) begin
              phase_nxt = fdf_pkg::PH_NORMAL;
            end
          end
          fdf_pkg::PH_CONFIRMED: begin
            phase_nxt = fdf_pkg::PH_CONFIRMED;
          end
          default: begin
            if (mag_r < cfg.freefall_level) begin
              phase_nxt = fdf_pkg::PH_FREEFALL;
              ffs_nxt   = now_r;
            end else begin
              phase_nxt = fdf_pkg::PH_NORMAL;
            end
          end
        endcase
        tdata_nxt  = {4'b0000, mag_r, phase_nxt,
                      (phase_nxt == fdf_pkg::PH_CONFIRMED)};
        tvalid_nxt = 1'b1;
        st_nxt     = fdf_pkg::BK_OUT;
      end
      fdf_pkg::BK_OUT: begin
        if (out_tready) begin
          tvalid_nxt = 1'b0;
          st_nxt     = fdf_pkg::BK_IDLE;
        end
      end
      default: begin
        st_nxt = fdf_pkg::BK_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/fall_detector_fsm_top.sv =====
// fall detector top level: config registers, front end, queue and back end
// the front end takes no new beat until the last one has passed its shared squarer
// and 16-step root and has been pushed into the queue
// the back end sums the window, decides and waits on the output per beat, hidden by the queue
// reset: synchronous active-low rst_n clears phase, timestamps, window and config defaults
module fall_detector_fsm_top #(
  parameter int AVG_WINDOW = fdf_pkg::AVG_WINDOW_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [79:0]                      in_tdata,   // accel_x, accel_y, accel_z, now_ms
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [23:0]                      out_tdata,  // fall_confirmed, phase, magnitude
  input  logic                             cfg_we,
  input  logic [fdf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fdf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  fdf_pkg::cfg_t cfg_r;
  logic q_wvalid, q_wready, q_rvalid, q_rready;
  fdf_pkg::sample_t q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.freefall_level  <= fdf_pkg::DEF_FREEFALL_LEVEL;
      cfg_r.impact_level    <= fdf_pkg::DEF_IMPACT_LEVEL;
      cfg_r.recovery_level  <= fdf_pkg::DEF_RECOVERY_LEVEL;
      cfg_r.freefall_max_ms <= fdf_pkg::DEF_FREEFALL_MAX_MS;
      cfg_r.settle_ms       <= fdf_pkg::DEF_SETTLE_MS;
      cfg_r.confirm_ms      <= fdf_pkg::DEF_CONFIRM_MS;
    end else if (cfg_we) begin
      case (cfg_index)
        fdf_pkg::CFG_FREEFALL_LEVEL:  cfg_r.freefall_level  <= cfg_wdata;
        fdf_pkg::CFG_IMPACT_LEVEL:    cfg_r.impact_level    <= cfg_wdata;
        fdf_pkg::CFG_RECOVERY_LEVEL:  cfg_r.recovery_level  <= cfg_wdata;
        fdf_pkg::CFG_FREEFALL_MAX_MS: cfg_r.freefall_max_ms <= cfg_wdata;
        fdf_pkg::CFG_SETTLE_MS:       cfg_r.settle_ms       <= cfg_wdata;
        fdf_pkg::CFG_CONFIRM_MS:      cfg_r.confirm_ms      <= cfg_wdata;
        default:                      cfg_r <= cfg_r;
      endcase
    end
  end

  fdf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .accel_x  (signed'(in_tdata[15:0])),
    .accel_y  (signed'(in_tdata[31:16])),
    .accel_z  (signed'(in_tdata[47:32])),
    .now_ms   (in_tdata[79:48]),
    .q_wvalid (q_wvalid),
    .q_wready (q_wready),
    .q_wdata  (q_wdata)
  );

  fdf_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wvalid (q_wvalid),
    .wready (q_wready),
    .wdata  (q_wdata),
    .rvalid (q_rvalid),
    .rready (q_rready),
    .rdata  (q_rdata)
  );

  fdf_back #(
    .AVG_WINDOW (AVG_WINDOW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_rvalid   (q_rvalid),
    .q_rready   (q_rready),
    .q_rdata    (q_rdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_confirm_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tdata[3:1] == fdf_pkg::PH_CONFIRMED)))
    else $error("confirm flag disagrees with phase");

  a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[19:4] <= fdf_pkg::MAG_MAX))
    else $error("magnitude above largest possible root");

  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("front end took a beat while still working");

endmodule
